### rtl/sle_pkg.sv
package sle_pkg;

  // scan code constants
  localparam logic [7:0] CODE_MAX   = 8'd57;
  localparam logic [7:0] CODE_ERASE = 8'h0E;
  localparam logic [7:0] CODE_ENTER = 8'h1C;
  localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;
  localparam logic [6:0] CHAR_NONE    = 7'h00;

  // command classes passed from the front to the back
  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_ERASE = 2'd1,
    OP_ENTER = 2'd2
  } op_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ECHO_CHAR  = 2'd0,
    KIND_ECHO_ERASE = 2'd1,
    KIND_LINE_CHAR  = 2'd2,
    KIND_LINE_END   = 2'd3
  } kind_e;

  // back sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_END  = 2'd2
  } state_e;

  // head of the command queue
  typedef struct packed {
    logic       valid;
    op_e        op;
    logic [6:0] ch;
  } cmd_t;

  // set-1 make code to ascii, codes without a character give '?'
  function automatic logic [6:0] key_map(input logic [5:0] code);
    logic [6:0] ch;
    unique case (code)
      6'd2:  ch = 7'h31;
      6'd3:  ch = 7'h32;
      6'd4:  ch = 7'h33;
      6'd5:  ch = 7'h34;
      6'd6:  ch = 7'h35;
      6'd7:  ch = 7'h36;
      6'd8:  ch = 7'h37;
      6'd9:  ch = 7'h38;
      6'd10: ch = 7'h39;
      6'd11: ch = 7'h30;
      6'd12: ch = 7'h2D;
      6'd13: ch = 7'h3D;
      6'd16: ch = 7'h51;
      6'd17: ch = 7'h57;
      6'd18: ch = 7'h45;
      6'd19: ch = 7'h52;
      6'd20: ch = 7'h54;
      6'd21: ch = 7'h59;
      6'd22: ch = 7'h55;
      6'd23: ch = 7'h49;
      6'd24: ch = 7'h4F;
      6'd25: ch = 7'h50;
      6'd26: ch = 7'h5B;
      6'd27: ch = 7'h5D;
      6'd30: ch = 7'h41;
      6'd31: ch = 7'h53;
      6'd32: ch = 7'h44;
      6'd33: ch = 7'h46;
      6'd34: ch = 7'h47;
      6'd35: ch = 7'h48;
      6'd36: ch = 7'h4A;
      6'd37: ch = 7'h4B;
      6'd38: ch = 7'h4C;
      6'd39: ch = 7'h3B;
      6'd40: ch = 7'h27;
      6'd41: ch = 7'h60;
      6'd43: ch = 7'h5C;
      6'd44: ch = 7'h5A;
      6'd45: ch = 7'h58;
      6'd46: ch = 7'h43;
      6'd47: ch = 7'h56;
      6'd48: ch = 7'h42;
      6'd49: ch = 7'h4E;
      6'd50: ch = 7'h4D;
      6'd51: ch = 7'h2C;
      6'd52: ch = 7'h2E;
      6'd53: ch = 7'h2F;
      6'd57: ch = 7'h20;
      default: ch = CHAR_UNKNOWN;
    endcase
    return ch;
  endfunction

endpackage

### rtl/sle_front.sv
module sle_front
  import sle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] scan_byte_i,
  output logic       full_o,
  output cmd_t       cmd_o,
  input  logic       cmd_take_i
);

  logic [6:0] entry_ch_q [2];
  op_e        entry_kind_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  logic       accept;
  logic       keep;
  op_e        op;
  logic [6:0] ch;
  logic       take;

  // classify the incoming code
  always_comb begin
    op = OP_CHAR;
    ch = key_map(scan_byte_i[5:0]);
    if (scan_byte_i == CODE_ERASE) begin
      op = OP_ERASE;
      ch = CHAR_NONE;
    end else if (scan_byte_i == CODE_ENTER) begin
      op = OP_ENTER;
      ch = CHAR_NONE;
    end
  end

  assign full_o = (count_q == 2'd2);
  assign accept = push_i && !full_o;
  assign keep   = accept && (scan_byte_i <= CODE_MAX);
  assign take   = cmd_take_i && (count_q != 2'd0);

  // queue head to the back
  assign cmd_o.valid = (count_q != 2'd0);
  assign cmd_o.op    = entry_kind_q[rd_ptr_q];
  assign cmd_o.ch    = entry_ch_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = keep ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = take ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (keep && !take) begin
      count_d = count_q + 2'd1;
    end else if (take && !keep) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue entries
  always_ff @(posedge clk_i) begin
    if (keep) begin
      entry_kind_q[wr_ptr_q] <= op;
      entry_ch_q[wr_ptr_q]   <= ch;
    end
  end

endmodule

### rtl/sle_back.sv
module sle_back
  import sle_pkg::*;
#(
  parameter int LINE_CHARS = 63
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output logic       cmd_take_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [1:0] item_kind_o,
  output logic [6:0] char_code_o,
  output logic       is_last_o
);

  localparam int LEN_W  = $clog2(LINE_CHARS + 1);
  localparam int ADDR_W = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
  localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CHARS);

  logic [6:0]        line_mem [LINE_CHARS];
  logic [6:0]        rd_data_q;
  logic [ADDR_W-1:0] rd_addr;

  state_e            state_q, state_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [ADDR_W-1:0] idx_q, idx_d;

  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q, out_kind_d;
  logic [6:0]        out_ch_q, out_ch_d;
  logic              out_last_q, out_last_d;

  logic              slot_free;
  logic              load;
  logic              wr_en;
  logic              walk_done;

  assign slot_free  = !out_valid_q || pop_i;
  assign cmd_take_o = (state_q == ST_IDLE) && cmd_i.valid && slot_free;
  assign walk_done  = (LEN_W'(idx_q) + LEN_W'(1)) == len_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_take_o && (cmd_i.op == OP_ENTER) && (len_q != '0)) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (slot_free && walk_done) begin
          state_d = ST_END;
        end
      end
      ST_END: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control and result loading
  always_comb begin
    len_d      = len_q;
    idx_d      = '0;
    load       = 1'b0;
    wr_en      = 1'b0;
    out_kind_d = out_kind_q;
    out_ch_d   = out_ch_q;
    out_last_d = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_take_o) begin
          unique case (cmd_i.op)
            OP_ERASE: begin
              if (len_q != '0) begin
                len_d      = len_q - LEN_W'(1);
                load       = 1'b1;
                out_kind_d = KIND_ECHO_ERASE;
                out_ch_d   = CHAR_NONE;
                out_last_d = 1'b1;
              end
            end
            OP_ENTER: begin
              if (len_q == '0) begin
                load       = 1'b1;
                out_kind_d = KIND_LINE_END;
                out_ch_d   = CHAR_NONE;
                out_last_d = 1'b1;
              end
            end
            OP_CHAR: begin
              if (len_q < CAP) begin
                wr_en      = 1'b1;
                len_d      = len_q + LEN_W'(1);
                load       = 1'b1;
                out_kind_d = KIND_ECHO_CHAR;
                out_ch_d   = cmd_i.ch;
                out_last_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        idx_d = idx_q;
        if (slot_free) begin
          load       = 1'b1;
          out_kind_d = KIND_LINE_CHAR;
          out_ch_d   = rd_data_q;
          out_last_d = 1'b0;
          idx_d      = walk_done ? '0 : idx_q + ADDR_W'(1);
        end
      end
      ST_END: begin
        if (slot_free) begin
          load       = 1'b1;
          len_d      = '0;
          out_kind_d = KIND_LINE_END;
          out_ch_d   = CHAR_NONE;
          out_last_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_ch_q   <= out_ch_d;
    out_last_q <= out_last_d;
  end

  // line memory, read address tracks the next walk index
  assign rd_addr = idx_d;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[len_q[ADDR_W-1:0]] <= cmd_i.ch;
    end
    rd_data_q <= line_mem[rd_addr];
  end

  assign empty_o     = !out_valid_q;
  assign item_kind_o = out_kind_q;
  assign char_code_o = out_ch_q;
  assign is_last_o   = out_last_q;

endmodule

### rtl/scancode_line_editor_unit.sv
// channel  | ports                                   | handshake
// input    | scan_byte_i                             | push_i / full_o
// result   | item_kind_o, char_code_o, is_last_o     | pop_i / empty_o
//
// a code enters a two-entry command queue; the back takes one command per
// cycle when it is idle and its output register is free, and enter sends one
// stored char per cycle from the line memory read port while the output
// register is free, then the line end, or only the line end on an empty line.
// reset clears the queue, the line length and the output register; stalls on
// pop hold the back, and once two commands wait full_o holds the input too.
module scancode_line_editor_unit
  import sle_pkg::*;
#(
  parameter int LINE_CHARS = 63
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] scan_byte_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [1:0] item_kind_o,
  output logic [6:0] char_code_o,
  output logic       is_last_o
);

  cmd_t cmd;
  logic cmd_take;

  // classify and queue
  sle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .scan_byte_i (scan_byte_i),
    .full_o      (full_o),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  // line store and result sequencing
  sle_back #(
    .LINE_CHARS (LINE_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .item_kind_o (item_kind_o),
    .char_code_o (char_code_o),
    .is_last_o   (is_last_o)
  );

endmodule
